// File: hdl/dptc_pkg.sv
`default_nettype none

package dptc_pkg;

   localparam int POS_W    = 24;
   localparam int RAD_W    = 16;
   localparam int MARGIN_W = 20;
   localparam int FRAC_W   = 16;
   localparam int TIME_W   = FRAC_W + 1;

   // Differences of positions and velocities, and the radius sum.
   localparam int DIFF_W = POS_W + 1;
   localparam int RSUM_W = RAD_W + 1;
   // Signed products and the signed dot products b and c.
   localparam int SUM_W  = 2 * DIFF_W;
   // Magnitudes of b, a and c.
   localparam int MAG_W  = 2 * POS_W + 1;
   // Split of a magnitude for the partial products.
   localparam int HALF_W = (MAG_W + 1) / 2;
   // Discriminant b*b -+ a*|c| and its integer square root.
   localparam int DISC_W   = 2 * MAG_W + 1;
   localparam int SQ_STEPS = (DISC_W + 1) / 2;
   localparam int ROOT_W   = SQ_STEPS;
   localparam int REM_W    = ROOT_W + 3;
   // Signed b - s and the divider remainder.
   localparam int NUM_W = ROOT_W + 1;
   localparam int DIV_W = ROOT_W;

   localparam logic [MARGIN_W-1:0] MARGIN_RESET = MARGIN_W'(1);
   localparam logic [TIME_W-1:0]   TIME_NONE    = {1'b1, {FRAC_W{1'b0}}};

   typedef struct packed {
      logic signed [POS_W-1:0] first_pos_x;
      logic signed [POS_W-1:0] first_pos_y;
      logic signed [POS_W-1:0] first_vel_x;
      logic signed [POS_W-1:0] first_vel_y;
      logic [RAD_W-1:0]        first_radius;
      logic signed [POS_W-1:0] second_pos_x;
      logic signed [POS_W-1:0] second_pos_y;
      logic signed [POS_W-1:0] second_vel_x;
      logic signed [POS_W-1:0] second_vel_y;
      logic [RAD_W-1:0]        second_radius;
   } req_word_type;

   // Classified word handed from the front to the back.
   typedef struct packed {
      logic             skip;
      logic             c_neg;
      logic [MAG_W-1:0] b;
      logic [MAG_W-1:0] a;
      logic [MAG_W-1:0] c_mag;
   } fb_word_type;

endpackage

`default_nettype wire

// File: hdl/dptc_fifo.sv
`default_nettype none

module dptc_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == FULL_CNT);
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// File: hdl/dptc_front.sv
`default_nettype none

module dptc_front (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  push,
   output logic                                  full,
   input  dptc_pkg::req_word_type                req_word,
   input  logic [dptc_pkg::MARGIN_W-1:0]         margin,
   output logic                                  fb_push,
   input  logic                                  fb_full,
   output dptc_pkg::fb_word_type                 fb_word
);

   localparam int DIFF_W       = dptc_pkg::DIFF_W;
   localparam int RSUM_W       = dptc_pkg::RSUM_W;
   localparam int SUM_W        = dptc_pkg::SUM_W;
   localparam int MAG_W        = dptc_pkg::MAG_W;
   localparam int MARGIN_W     = dptc_pkg::MARGIN_W;
   localparam int FRONT_STAGES = 5;

   logic [FRONT_STAGES-1:0] valid_ff, valid_in;
   logic                    advance;

   dptc_pkg::req_word_type req_ff;
   logic signed [DIFF_W-1:0] dpx_ff, dpy_ff, dvx_ff, dvy_ff;
   logic signed [DIFF_W-1:0] dpx_in, dpy_in, dvx_in, dvy_in;
   logic [RSUM_W-1:0]        rsum_ff, rsum_in;
   logic signed [SUM_W-1:0]  pbx_ff, pby_ff, pax_ff, pay_ff, pcx_ff, pcy_ff;
   logic signed [SUM_W-1:0]  pbx_in, pby_in, pax_in, pay_in, pcx_in, pcy_in;
   logic [2*RSUM_W-1:0]      prr_ff, prr_in;
   logic signed [SUM_W-1:0]  b_ff, a_ff, c_ff, b_in, a_in, c_in;
   logic signed [SUM_W-1:0]  c_abs;
   dptc_pkg::fb_word_type    fb_ff, fb_in;

   // Stall the whole front only when the last word cannot leave.
   assign advance = !valid_ff[FRONT_STAGES-1] || !fb_full;
   assign full    = !advance;
   assign fb_push = valid_ff[FRONT_STAGES-1] && !fb_full;
   assign fb_word = fb_ff;
   assign valid_in = {valid_ff[FRONT_STAGES-2:0], push};

   always_comb begin
      dpx_in  = DIFF_W'(req_ff.first_pos_x) - DIFF_W'(req_ff.second_pos_x);
      dpy_in  = DIFF_W'(req_ff.first_pos_y) - DIFF_W'(req_ff.second_pos_y);
      dvx_in  = DIFF_W'(req_ff.second_vel_x) - DIFF_W'(req_ff.first_vel_x);
      dvy_in  = DIFF_W'(req_ff.second_vel_y) - DIFF_W'(req_ff.first_vel_y);
      rsum_in = RSUM_W'(req_ff.first_radius) + RSUM_W'(req_ff.second_radius);

      pbx_in = dpx_ff * dvx_ff;
      pby_in = dpy_ff * dvy_ff;
      pax_in = dvx_ff * dvx_ff;
      pay_in = dvy_ff * dvy_ff;
      pcx_in = dpx_ff * dpx_ff;
      pcy_in = dpy_ff * dpy_ff;
      prr_in = rsum_ff * rsum_ff;

      b_in = pbx_ff + pby_ff;
      a_in = pax_ff + pay_ff;
      c_in = pcx_ff + pcy_ff - $signed({{(SUM_W-2*RSUM_W){1'b0}}, prr_ff});

      // Classify: only a pair closing faster than the margin gets solved.
      c_abs       = c_ff[SUM_W-1] ? -c_ff : c_ff;
      fb_in.skip  = b_ff <= $signed({{(SUM_W-MARGIN_W){1'b0}}, margin});
      fb_in.c_neg = c_ff[SUM_W-1];
      fb_in.b     = b_ff[MAG_W-1:0];
      fb_in.a     = a_ff[MAG_W-1:0];
      fb_in.c_mag = c_abs[MAG_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         req_ff  <= req_word;
         dpx_ff  <= dpx_in;
         dpy_ff  <= dpy_in;
         dvx_ff  <= dvx_in;
         dvy_ff  <= dvy_in;
         rsum_ff <= rsum_in;
         pbx_ff  <= pbx_in;
         pby_ff  <= pby_in;
         pax_ff  <= pax_in;
         pay_ff  <= pay_in;
         pcx_ff  <= pcx_in;
         pcy_ff  <= pcy_in;
         prr_ff  <= prr_in;
         b_ff    <= b_in;
         a_ff    <= a_in;
         c_ff    <= c_in;
         fb_ff   <= fb_in;
      end
   end

endmodule

`default_nettype wire

// File: hdl/dptc_back.sv
`default_nettype none

module dptc_back (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              fb_empty,
   input  dptc_pkg::fb_word_type             fb_word,
   output logic                              fb_pop,
   output logic                              out_push,
   input  logic                              out_full,
   output logic [dptc_pkg::TIME_W-1:0]       out_time
);

   localparam int MAG_W    = dptc_pkg::MAG_W;
   localparam int HALF_W   = dptc_pkg::HALF_W;
   localparam int DISC_W   = dptc_pkg::DISC_W;
   localparam int SQ_STEPS = dptc_pkg::SQ_STEPS;
   localparam int ROOT_W   = dptc_pkg::ROOT_W;
   localparam int REM_W    = dptc_pkg::REM_W;
   localparam int NUM_W    = dptc_pkg::NUM_W;
   localparam int DIV_W    = dptc_pkg::DIV_W;
   localparam int FRAC_W   = dptc_pkg::FRAC_W;
   localparam int RAD2_W   = 2 * SQ_STEPS;
   localparam int PP_W     = 2 * HALF_W;
   localparam int BACK_STAGES = 4 + SQ_STEPS + 3 + FRAC_W;

   typedef struct packed {
      logic             skip;
      logic             none;
      logic [MAG_W-1:0] b;
      logic [MAG_W-1:0] a;
   } side_type;

   logic [BACK_STAGES-1:0] valid_ff, valid_in;
   logic                   advance;

   dptc_pkg::fb_word_type word_ff, mul_ff, sum_ff;
   logic [HALF_W-1:0]     b_lo, b_hi, a_lo, a_hi, c_lo, c_hi;
   logic [PP_W-1:0]       pb_ll_ff, pb_lh_ff, pb_hh_ff;
   logic [PP_W-1:0]       pac_ll_ff, pac_lh_ff, pac_hl_ff, pac_hh_ff;
   logic [PP_W-1:0]       pb_ll_in, pb_lh_in, pb_hh_in;
   logic [PP_W-1:0]       pac_ll_in, pac_lh_in, pac_hl_in, pac_hh_in;
   logic [DISC_W-1:0]     bb_ff, ac_ff, bb_in, ac_in, disc;

   logic [RAD2_W-1:0] sq_rad_ff  [SQ_STEPS+1];
   logic [RAD2_W-1:0] sq_rad_in  [SQ_STEPS+1];
   logic [REM_W-1:0]  sq_rem_ff  [SQ_STEPS+1];
   logic [REM_W-1:0]  sq_rem_in  [SQ_STEPS+1];
   logic [ROOT_W-1:0] sq_root_ff [SQ_STEPS+1];
   logic [ROOT_W-1:0] sq_root_in [SQ_STEPS+1];
   side_type          sq_side_ff [SQ_STEPS+1];
   side_type          sq_side_in [SQ_STEPS+1];

   logic [NUM_W-1:0]  diff_ff, diff_in, diff_neg;
   logic [ROOT_W-1:0] mag_ff, mag_in;
   side_type          n1_side_ff, n2_side_ff;

   logic [DIV_W-1:0]  dv_rem_ff [FRAC_W+1];
   logic [DIV_W-1:0]  dv_rem_in [FRAC_W+1];
   logic [FRAC_W-1:0] dv_q_ff   [FRAC_W+1];
   logic [FRAC_W-1:0] dv_q_in   [FRAC_W+1];
   logic [MAG_W-1:0]  dv_a_ff   [FRAC_W+1];
   logic [MAG_W-1:0]  dv_a_in   [FRAC_W+1];
   logic              dv_sat_ff [FRAC_W+1];
   logic              dv_sat_in [FRAC_W+1];

   assign advance  = !valid_ff[BACK_STAGES-1] || !out_full;
   assign fb_pop   = advance && !fb_empty;
   assign out_push = valid_ff[BACK_STAGES-1] && !out_full;
   assign valid_in = {valid_ff[BACK_STAGES-2:0], !fb_empty};
   assign out_time = dv_sat_ff[FRAC_W] ? dptc_pkg::TIME_NONE
                                       : {1'b0, dv_q_ff[FRAC_W]};

   // Partial products of b*b and a*|c|, then their sums.
   always_comb begin
      b_lo = word_ff.b[HALF_W-1:0];
      b_hi = HALF_W'(word_ff.b >> HALF_W);
      a_lo = word_ff.a[HALF_W-1:0];
      a_hi = HALF_W'(word_ff.a >> HALF_W);
      c_lo = word_ff.c_mag[HALF_W-1:0];
      c_hi = HALF_W'(word_ff.c_mag >> HALF_W);
      pb_ll_in  = b_lo * b_lo;
      pb_lh_in  = b_lo * b_hi;
      pb_hh_in  = b_hi * b_hi;
      pac_ll_in = a_lo * c_lo;
      pac_lh_in = a_lo * c_hi;
      pac_hl_in = a_hi * c_lo;
      pac_hh_in = a_hi * c_hi;
      bb_in = (DISC_W'(pb_hh_ff) << (2 * HALF_W))
            + (DISC_W'(pb_lh_ff) << (HALF_W + 1))
            + DISC_W'(pb_ll_ff);
      ac_in = (DISC_W'(pac_hh_ff) << (2 * HALF_W))
            + ((DISC_W'(pac_lh_ff) + DISC_W'(pac_hl_ff)) << HALF_W)
            + DISC_W'(pac_ll_ff);
   end

   // Discriminant, then one root bit per square root stage.
   always_comb begin
      logic [REM_W-1:0] rem_sh;
      logic [REM_W-1:0] trial;
      disc = sum_ff.c_neg ? bb_ff + ac_ff : bb_ff - ac_ff;
      sq_rad_in[0]       = RAD2_W'(disc);
      sq_rem_in[0]       = '0;
      sq_root_in[0]      = '0;
      sq_side_in[0].skip = sum_ff.skip;
      sq_side_in[0].none = !sum_ff.c_neg && (bb_ff <= ac_ff);
      sq_side_in[0].b    = sum_ff.b;
      sq_side_in[0].a    = sum_ff.a;
      for (int k = 0; k < SQ_STEPS; k++) begin
         rem_sh = {sq_rem_ff[k][REM_W-3:0], sq_rad_ff[k][RAD2_W-1 -: 2]};
         trial  = {{(REM_W-ROOT_W-2){1'b0}}, sq_root_ff[k], 2'b01};
         sq_rad_in[k+1]  = sq_rad_ff[k] << 2;
         sq_side_in[k+1] = sq_side_ff[k];
         if (rem_sh >= trial) begin
            sq_rem_in[k+1]  = rem_sh - trial;
            sq_root_in[k+1] = {sq_root_ff[k][ROOT_W-2:0], 1'b1};
         end else begin
            sq_rem_in[k+1]  = rem_sh;
            sq_root_in[k+1] = {sq_root_ff[k][ROOT_W-2:0], 1'b0};
         end
      end
   end

   // Numerator magnitude |b - s|, saturation, then one quotient bit a stage.
   always_comb begin
      logic [DIV_W-1:0] rem_sh;
      logic [DIV_W-1:0] a_ext;
      diff_in  = NUM_W'(sq_side_ff[SQ_STEPS].b) - NUM_W'(sq_root_ff[SQ_STEPS]);
      diff_neg = -diff_ff;
      mag_in   = diff_ff[NUM_W-1] ? diff_neg[ROOT_W-1:0] : diff_ff[ROOT_W-1:0];
      dv_rem_in[0] = DIV_W'(mag_ff);
      dv_q_in[0]   = '0;
      dv_a_in[0]   = n2_side_ff.a;
      dv_sat_in[0] = n2_side_ff.skip || n2_side_ff.none
                  || (mag_ff >= ROOT_W'(n2_side_ff.a));
      for (int k = 0; k < FRAC_W; k++) begin
         rem_sh = {dv_rem_ff[k][DIV_W-2:0], 1'b0};
         a_ext  = DIV_W'(dv_a_ff[k]);
         dv_a_in[k+1]   = dv_a_ff[k];
         dv_sat_in[k+1] = dv_sat_ff[k];
         if (rem_sh >= a_ext) begin
            dv_rem_in[k+1] = rem_sh - a_ext;
            dv_q_in[k+1]   = {dv_q_ff[k][FRAC_W-2:0], 1'b1};
         end else begin
            dv_rem_in[k+1] = rem_sh;
            dv_q_in[k+1]   = {dv_q_ff[k][FRAC_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         word_ff    <= fb_word;
         mul_ff     <= word_ff;
         pb_ll_ff   <= pb_ll_in;
         pb_lh_ff   <= pb_lh_in;
         pb_hh_ff   <= pb_hh_in;
         pac_ll_ff  <= pac_ll_in;
         pac_lh_ff  <= pac_lh_in;
         pac_hl_ff  <= pac_hl_in;
         pac_hh_ff  <= pac_hh_in;
         sum_ff     <= mul_ff;
         bb_ff      <= bb_in;
         ac_ff      <= ac_in;
         sq_rad_ff  <= sq_rad_in;
         sq_rem_ff  <= sq_rem_in;
         sq_root_ff <= sq_root_in;
         sq_side_ff <= sq_side_in;
         diff_ff    <= diff_in;
         n1_side_ff <= sq_side_ff[SQ_STEPS];
         mag_ff     <= mag_in;
         n2_side_ff <= n1_side_ff;
         dv_rem_ff  <= dv_rem_in;
         dv_q_ff    <= dv_q_in;
         dv_a_ff    <= dv_a_in;
         dv_sat_ff  <= dv_sat_in;
      end
   end

endmodule

`default_nettype wire

// File: hdl/disc_pair_time_to_collision.sv
`default_nettype none

// Time of first contact of two moving discs within one step. Push one disc
// pair per word (positions and velocities signed Q16.8, radii unsigned Q8.8)
// and pop one hit_time word per pair, in order, as unsigned Q1.16 where
// 65536 means no contact inside the step (not closing faster than
// csr_approach_margin, no real root, or a root of magnitude one or more).
// The block takes a new word every cycle while full is low and returns one
// every cycle while pop is held; a word reaches the rsp ports through the
// 50-stage square root pipeline and the 16-stage divider behind it.
// A front pipeline forms the dot products and classifies the pair; a small
// queue decouples it from the back pipeline that solves for the root, and an
// output queue lets results wait while new words keep coming in. Write
// csr_approach_margin only while nothing is in flight; csr_ready is always
// high.
module disc_pair_time_to_collision #(
   parameter int MID_DEPTH = 4,
   parameter int OUT_DEPTH = 2
) (
   input  logic                                clock,
   input  logic                                reset,
   // request words
   input  logic                                push,
   output logic                                full,
   input  logic signed [dptc_pkg::POS_W-1:0]   req_first_pos_x,
   input  logic signed [dptc_pkg::POS_W-1:0]   req_first_pos_y,
   input  logic signed [dptc_pkg::POS_W-1:0]   req_first_vel_x,
   input  logic signed [dptc_pkg::POS_W-1:0]   req_first_vel_y,
   input  logic [dptc_pkg::RAD_W-1:0]          req_first_radius,
   input  logic signed [dptc_pkg::POS_W-1:0]   req_second_pos_x,
   input  logic signed [dptc_pkg::POS_W-1:0]   req_second_pos_y,
   input  logic signed [dptc_pkg::POS_W-1:0]   req_second_vel_x,
   input  logic signed [dptc_pkg::POS_W-1:0]   req_second_vel_y,
   input  logic [dptc_pkg::RAD_W-1:0]          req_second_radius,
   // response words
   output logic                                empty,
   input  logic                                pop,
   output logic [dptc_pkg::TIME_W-1:0]         rsp_hit_time,
   // configuration
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [dptc_pkg::MARGIN_W-1:0]       csr_approach_margin
);

   localparam int FB_W = $bits(dptc_pkg::fb_word_type);

   logic [dptc_pkg::MARGIN_W-1:0] margin_ff, margin_in;
   dptc_pkg::req_word_type        req_word;
   dptc_pkg::fb_word_type         fb_in_word, fb_out_word;
   logic [FB_W-1:0]               fb_in_bits, fb_out_bits;
   logic                          fb_push, fb_full, fb_pop, fb_empty;
   logic                          out_push, out_full;
   logic [dptc_pkg::TIME_W-1:0]   out_time;

   // Take a margin write on every valid.
   assign csr_ready = 1'b1;
   assign margin_in = (csr_valid && csr_ready) ? csr_approach_margin : margin_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         margin_ff <= dptc_pkg::MARGIN_RESET;
      end else begin
         margin_ff <= margin_in;
      end
   end

   // Gather the request fields into one word.
   always_comb begin
      req_word.first_pos_x   = req_first_pos_x;
      req_word.first_pos_y   = req_first_pos_y;
      req_word.first_vel_x   = req_first_vel_x;
      req_word.first_vel_y   = req_first_vel_y;
      req_word.first_radius  = req_first_radius;
      req_word.second_pos_x  = req_second_pos_x;
      req_word.second_pos_y  = req_second_pos_y;
      req_word.second_vel_x  = req_second_vel_x;
      req_word.second_vel_y  = req_second_vel_y;
      req_word.second_radius = req_second_radius;
   end

   // Front: differences, dot products, margin test.
   dptc_front u_front (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_word (req_word),
      .margin   (margin_ff),
      .fb_push  (fb_push),
      .fb_full  (fb_full),
      .fb_word  (fb_in_word)
   );

   assign fb_in_bits  = fb_in_word;
   assign fb_out_word = dptc_pkg::fb_word_type'(fb_out_bits);

   // Decouple front and back.
   dptc_fifo #(
      .WIDTH (FB_W),
      .DEPTH (MID_DEPTH)
   ) u_mid_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (fb_push),
      .push_data (fb_in_bits),
      .full      (fb_full),
      .pop       (fb_pop),
      .pop_data  (fb_out_bits),
      .empty     (fb_empty)
   );

   // Back: wide products, square root, division.
   dptc_back u_back (
      .clock    (clock),
      .reset    (reset),
      .fb_empty (fb_empty),
      .fb_word  (fb_out_word),
      .fb_pop   (fb_pop),
      .out_push (out_push),
      .out_full (out_full),
      .out_time (out_time)
   );

   // Hold finished results until popped.
   dptc_fifo #(
      .WIDTH (dptc_pkg::TIME_W),
      .DEPTH (OUT_DEPTH)
   ) u_out_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (out_push),
      .push_data (out_time),
      .full      (out_full),
      .pop       (pop),
      .pop_data  (rsp_hit_time),
      .empty     (empty)
   );

endmodule

`default_nettype wire

// File: hdl/dptc_checker.sv
`default_nettype none

module dptc_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        push,
   input logic                        full,
   input logic                        pop,
   input logic                        empty,
   input logic [dptc_pkg::TIME_W-1:0] rsp_hit_time
);

   a_reset_drains: assert property (@(posedge clock)
      reset |=> empty && !full)
      else $error("queues not cleared by reset");

   a_time_range: assert property (@(posedge clock) disable iff (reset)
      !empty && rsp_hit_time[dptc_pkg::TIME_W-1] |-> rsp_hit_time[dptc_pkg::FRAC_W-1:0] == '0)
      else $error("hit_time above one step");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      !empty && !pop |=> !empty && $stable(rsp_hit_time))
      else $error("waiting result changed");

   a_push_not_lost: assert property (@(posedge clock) disable iff (reset)
      push && !full && empty |=> !full || push)
      else $error("full raised with nothing pushed");

endmodule

bind disc_pair_time_to_collision dptc_checker u_checker (.*);

`default_nettype wire
